>>> src/orsfp_pkg.sv
// Shared types and constants for the offset-ranked set with floor pruning.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package orsfp_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_RAISE  = 2'd1,
      CMD_LOWER  = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] answer;
      logic        found;
      logic [8:0]  present_count;
      logic [31:0] departed_total;
      logic        full_drop;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_PR_RD,
      S_PR_CMP,
      S_Q_RD,
      S_Q_ANS,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic ins_rd;
      logic ins_cmp;
      logic pr_rd;
      logic pr_cmp;
      logic q_rd;
      logic q_ans;
      logic finish;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ins_ok;
      logic q_ok;
      logic at_zero;
      logic ins_less;
      logic pr_more;
   } sts_type;

endpackage
`default_nettype wire

>>> src/offset_ranked_set_with_floor_prune_top.sv
// Top level of the offset-ranked set with floor pruning.
// Depends on orsfp_pkg, orsfp_ctrl and orsfp_dpath.
//
// The block keeps a sorted multiset of up to CAPACITY values, stored relative
// to a global offset. A request is taken at a rising edge where start is high
// and busy is low; req_data carries the command and its value. Insert places a
// value at or above the floor into sorted order, raise adds to the offset,
// lower subtracts from the offset and evicts every entry below the floor, and
// query returns the k-th largest actual value.
// Each request produces exactly one response, shown on rsp_data for a single
// cycle with rsp_strobe high. The receiver cannot stall, so the response is
// simply taken in that cycle.
// Raise goes straight to finish; query reads and answers unless k is out of
// range. Insert reads and compares per entry moved, or finishes at once when
// dropped or below the floor; lower reads and compares per entry present.
// The entry memory has one read and one write port, so each insertion shift
// and prune step takes a read and a compare state. Busy stays high until the
// response is registered; a new request can be taken in the strobe cycle.
// The floor register is written through csr_we/csr_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Synchronous reset empties the set, clears the offset, floor and totals;
// the memory needs no clearing since only slots below the count are read.
`default_nettype none
module offset_ranked_set_with_floor_prune_top #(
   parameter int CAPACITY = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire orsfp_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output orsfp_pkg::rsp_type      rsp_data,
   input  wire logic               csr_we,
   input  wire logic [31:0]        csr_wdata
);

   orsfp_pkg::ctl_type ctl;
   orsfp_pkg::sts_type sts;

   orsfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_data.cmd),
      .sts        (sts),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   orsfp_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> src/orsfp_ctrl.sv
// Controller state machine for the offset-ranked set.
// Depends on orsfp_pkg; drives the datapath through ctl_type commands.
`default_nettype none
module orsfp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire orsfp_pkg::cmd_type  req_cmd,
   input  wire orsfp_pkg::sts_type  sts,
   output orsfp_pkg::ctl_type       ctl,
   output logic                     busy,
   output logic                     rsp_strobe
);

   orsfp_pkg::state_type state_ff, state_in;
   logic                 strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= orsfp_pkg::S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= ctl.finish;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         orsfp_pkg::S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               case (req_cmd)
                  orsfp_pkg::CMD_INSERT:
                     state_in = sts.ins_ok ? orsfp_pkg::S_INS_RD : orsfp_pkg::S_FINISH;
                  orsfp_pkg::CMD_RAISE:  state_in = orsfp_pkg::S_FINISH;
                  orsfp_pkg::CMD_LOWER:  state_in = orsfp_pkg::S_PR_RD;
                  orsfp_pkg::CMD_QUERY:
                     state_in = sts.q_ok ? orsfp_pkg::S_Q_RD : orsfp_pkg::S_FINISH;
                  default:               state_in = orsfp_pkg::S_FINISH;
               endcase
            end
         end
         orsfp_pkg::S_INS_RD: begin
            ctl.ins_rd = 1'b1;
            state_in   = sts.at_zero ? orsfp_pkg::S_FINISH : orsfp_pkg::S_INS_CMP;
         end
         orsfp_pkg::S_INS_CMP: begin
            ctl.ins_cmp = 1'b1;
            state_in    = sts.ins_less ? orsfp_pkg::S_INS_RD : orsfp_pkg::S_FINISH;
         end
         orsfp_pkg::S_PR_RD: begin
            ctl.pr_rd = 1'b1;
            state_in  = sts.pr_more ? orsfp_pkg::S_PR_CMP : orsfp_pkg::S_FINISH;
         end
         orsfp_pkg::S_PR_CMP: begin
            ctl.pr_cmp = 1'b1;
            state_in   = orsfp_pkg::S_PR_RD;
         end
         orsfp_pkg::S_Q_RD: begin
            ctl.q_rd = 1'b1;
            state_in = orsfp_pkg::S_Q_ANS;
         end
         orsfp_pkg::S_Q_ANS: begin
            ctl.q_ans = 1'b1;
            state_in  = orsfp_pkg::S_FINISH;
         end
         orsfp_pkg::S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = orsfp_pkg::S_IDLE;
         end
         default: state_in = orsfp_pkg::S_IDLE;
      endcase
   end

   assign busy       = (state_ff != orsfp_pkg::S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

>>> src/orsfp_dpath.sv
// Datapath for the offset-ranked set: entry memory, count, offset, floor and totals.
// Depends on orsfp_pkg; sequenced by orsfp_ctrl.
`default_nettype none
module orsfp_dpath #(
   parameter int CAPACITY = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire orsfp_pkg::req_type req_data,
   input  wire logic               csr_we,
   input  wire logic [31:0]        csr_wdata,
   input  wire orsfp_pkg::ctl_type ctl,
   output orsfp_pkg::sts_type      sts,
   output orsfp_pkg::rsp_type      rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [31:0]       mem [CAPACITY];
   logic [31:0]       rdata_ff;
   logic [CNT_W-1:0]  count_ff, i_ff, r_ff, w_ff;
   logic [31:0]       offset_ff, total_ff, floor_ff, stored_ff, answer_ff;
   logic              found_ff, drop_ff;
   orsfp_pkg::rsp_type rsp_ff;

   logic              below, full, is_ins, is_qry;
   logic              we, rd_en;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [31:0]       wdata, actual;
   logic [CNT_W+8:0]  count_ext;

   assign below  = $signed(req_data.value) < $signed(floor_ff);
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign is_ins = (req_data.cmd == orsfp_pkg::CMD_INSERT);
   assign is_qry = (req_data.cmd == orsfp_pkg::CMD_QUERY);
   assign actual = rdata_ff + offset_ff;

   assign sts.ins_ok   = !below && !full;
   assign sts.q_ok     = !req_data.value[31] && (req_data.value != 32'd0)
                         && (req_data.value <= 32'(count_ff));
   assign sts.at_zero  = (i_ff == '0);
   assign sts.ins_less = $signed(stored_ff) < $signed(rdata_ff);
   assign sts.pr_more  = (r_ff < count_ff);

   // Memory port selection.
   always_comb begin
      we    = 1'b0;
      waddr = i_ff[ADDR_W-1:0];
      wdata = stored_ff;
      rd_en = 1'b0;
      raddr = i_ff[ADDR_W-1:0];
      if (ctl.ins_rd) begin
         if (sts.at_zero) begin
            we = 1'b1;
         end else begin
            rd_en = 1'b1;
            raddr = ADDR_W'(i_ff - 1'b1);
         end
      end
      if (ctl.ins_cmp) begin
         we = 1'b1;
         if (sts.ins_less) begin
            wdata = rdata_ff;
         end
      end
      if (ctl.pr_rd) begin
         rd_en = 1'b1;
         raddr = r_ff[ADDR_W-1:0];
      end
      if (ctl.pr_cmp && !($signed(actual) < $signed(floor_ff))) begin
         we    = 1'b1;
         waddr = w_ff[ADDR_W-1:0];
         wdata = rdata_ff;
      end
      if (ctl.q_rd) begin
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         offset_ff <= '0;
         total_ff  <= '0;
         floor_ff  <= '0;
      end else begin
         if (csr_we) begin
            floor_ff <= csr_wdata;
         end
         if (ctl.load && req_data.cmd == orsfp_pkg::CMD_RAISE) begin
            offset_ff <= offset_ff + req_data.value;
         end
         if (ctl.load && req_data.cmd == orsfp_pkg::CMD_LOWER) begin
            offset_ff <= offset_ff - req_data.value;
         end
         if ((ctl.ins_rd && sts.at_zero) || (ctl.ins_cmp && !sts.ins_less)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (ctl.pr_rd && !sts.pr_more) begin
            count_ff <= w_ff;
         end
         if (ctl.pr_cmp && ($signed(actual) < $signed(floor_ff))) begin
            total_ff <= total_ff + 32'd1;
         end
      end
   end

   // Payload and index registers.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         stored_ff <= req_data.value - offset_ff;
         i_ff      <= is_qry ? CNT_W'(count_ff - req_data.value[CNT_W-1:0]) : count_ff;
         r_ff      <= '0;
         w_ff      <= '0;
         answer_ff <= '0;
         found_ff  <= 1'b0;
         drop_ff   <= is_ins && !below && full;
      end
      if (ctl.ins_cmp && sts.ins_less) begin
         i_ff <= i_ff - 1'b1;
      end
      if (ctl.pr_cmp) begin
         r_ff <= r_ff + 1'b1;
         if (!($signed(actual) < $signed(floor_ff))) begin
            w_ff <= w_ff + 1'b1;
         end
      end
      if (ctl.q_ans) begin
         answer_ff <= actual;
         found_ff  <= 1'b1;
      end
      if (ctl.finish) begin
         rsp_ff.answer         <= answer_ff;
         rsp_ff.found          <= found_ff;
         rsp_ff.present_count  <= count_ext[8:0];
         rsp_ff.departed_total <= total_ff;
         rsp_ff.full_drop      <= drop_ff;
      end
   end

   assign count_ext = {9'd0, count_ff};
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> src/orsfp_chk.sv
// Port-level checker for the offset-ranked set, bound to the top level.
// Depends on orsfp_pkg.
`default_nettype none
module orsfp_chk (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_strobe,
   input wire orsfp_pkg::rsp_type rsp_data
);

   // An accepted request keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // A response only follows a busy cycle.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without work");

   // A response that is not found carries a zero answer.
   a_answer_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |-> (rsp_data.answer == 32'd0))
      else $error("nonzero answer without found");

   // A query hit and a dropped insert never come together.
   a_found_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.found && rsp_data.full_drop))
      else $error("found and full_drop both set");

endmodule

bind offset_ranked_set_with_floor_prune_top orsfp_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
